// ===== design/assert_macros.svh =====
// Assertion helpers for the design files; gltw_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/gltw_pkg.sv =====
package gltw_pkg;

  localparam int MAX_DIM   = 64;
  localparam int MAX_CELLS = 64;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int DIM_W     = COORD_W + 1;
  localparam int ERR_W     = COORD_W + 3;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = $clog2(MAX_CELLS);
  localparam int IN_W      = 4 * COORD_W;
  localparam int OUT_W     = ((IDX_W + 7) / 8) * 8;
  localparam int REG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS    = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic stop;
  } dp_status_t;

  // A count of zero acts as one, a count above MAX_DIM acts as MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/gltw_datapath.sv =====
module gltw_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gltw_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [gltw_pkg::DIM_W-1:0]    cfg_data,
  input  logic [gltw_pkg::IN_W-1:0]     s_tdata,
  input  gltw_pkg::dp_cmd_t             cmd,
  output gltw_pkg::dp_status_t          status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gltw_pkg::OUT_W-1:0]    m_tdata,
  output logic                          m_tlast
);

  localparam int CW = gltw_pkg::COORD_W;
  localparam int DW = gltw_pkg::DIM_W;
  localparam int EW = gltw_pkg::ERR_W;
  localparam int IW = gltw_pkg::IDX_W;

  logic [DW-1:0] grid_columns;
  logic [DW-1:0] grid_rows;

  logic [CW-1:0] cur_col, cur_row, goal_col, goal_row;
  logic [CW-1:0] dx, ady;
  logic          col_down, row_down;
  logic signed [EW-1:0] step_error;
  logic [gltw_pkg::CNT_W-1:0] cnt;
  logic [IW-1:0] tile_index;

  logic [CW-1:0] in_scol, in_srow, in_ecol, in_erow;
  logic [DW-1:0] cols_eff, rows_eff;
  logic [CW-1:0] col_sat, row_sat;
  logic [DW+CW-1:0] row_base;
  logic [IW-1:0] idx_next;
  logic          at_last, xstep, ystep, stop;
  logic signed [EW:0] e2, neg_ady, pos_dx;
  logic signed [EW-1:0] err_next;

  assign in_scol = s_tdata[CW-1:0];
  assign in_srow = s_tdata[2*CW-1:CW];
  assign in_ecol = s_tdata[3*CW-1:2*CW];
  assign in_erow = s_tdata[4*CW-1:3*CW];

  // Cell index of the current walk position, saturated to the grid.
  always_comb begin
    cols_eff = gltw_pkg::eff_dim(grid_columns);
    rows_eff = gltw_pkg::eff_dim(grid_rows);
    col_sat  = ({1'b0, cur_col} >= cols_eff) ? CW'(cols_eff - DW'(1)) : cur_col;
    row_sat  = ({1'b0, cur_row} >= rows_eff) ? CW'(rows_eff - DW'(1)) : cur_row;
    row_base = cols_eff * row_sat;
    idx_next = IW'(row_base + (DW+CW)'(col_sat));
  end

  // Bresenham step decision for the current cell.
  always_comb begin
    at_last  = (cur_col == goal_col) && (cur_row == goal_row);
    e2       = {step_error, 1'b0};
    neg_ady  = -$signed({{(EW+1-CW){1'b0}}, ady});
    pos_dx   = $signed({{(EW+1-CW){1'b0}}, dx});
    xstep    = (e2 >= neg_ady);
    ystep    = (e2 <= pos_dx);
    stop     = at_last || (xstep && (cur_col == goal_col)) ||
               (ystep && (cur_row == goal_row)) ||
               (cnt == gltw_pkg::CNT_W'(gltw_pkg::MAX_CELLS - 1));
    err_next = step_error
             - (xstep ? $signed({{(EW-CW){1'b0}}, ady}) : '0)
             + (ystep ? $signed({{(EW-CW){1'b0}}, dx}) : '0);
  end

  assign status.out_free = !m_tvalid || m_tready;
  assign status.stop     = stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= gltw_pkg::DIM_RESET;
      grid_rows    <= gltw_pkg::DIM_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gltw_pkg::REG_GRID_COLUMNS: grid_columns <= cfg_data;
          gltw_pkg::REG_GRID_ROWS:    grid_rows    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.step) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_col    <= in_scol;
      cur_row    <= in_srow;
      goal_col   <= in_ecol;
      goal_row   <= in_erow;
      dx         <= (in_ecol >= in_scol) ? (in_ecol - in_scol) : (in_scol - in_ecol);
      ady        <= (in_erow >= in_srow) ? (in_erow - in_srow) : (in_srow - in_erow);
      col_down   <= !(in_scol < in_ecol);
      row_down   <= !(in_srow < in_erow);
      step_error <= $signed({{(EW-CW){1'b0}}, ((in_ecol >= in_scol) ?
                    (in_ecol - in_scol) : (in_scol - in_ecol))})
                  - $signed({{(EW-CW){1'b0}}, ((in_erow >= in_srow) ?
                    (in_erow - in_srow) : (in_srow - in_erow))});
      cnt        <= '0;
    end else if (cmd.step) begin
      tile_index <= idx_next;
      m_tlast    <= at_last;
      cnt        <= cnt + gltw_pkg::CNT_W'(1);
      step_error <= err_next;
      if (xstep) begin
        cur_col <= col_down ? (cur_col - CW'(1)) : (cur_col + CW'(1));
      end
      if (ystep) begin
        cur_row <= row_down ? (cur_row - CW'(1)) : (cur_row + CW'(1));
      end
    end
  end

  assign m_tdata = gltw_pkg::OUT_W'(tile_index);

endmodule

// ===== design/gltw_ctrl.sv =====
`include "assert_macros.svh"

module gltw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output gltw_pkg::dp_cmd_t    cmd,
  input  gltw_pkg::dp_status_t status
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t state;

  always_comb begin
    cmd.load = s_tvalid && s_tready;
    cmd.step = (state == ST_WALK) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state    <= ST_WALK;
            s_tready <= 1'b0;
          end
        end
        ST_WALK: begin
          if (cmd.step && status.stop) begin
            state    <= ST_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_ready_matches_idle, s_tready == (state == ST_IDLE), "ready out of step with state")
  `ASSERT_CLK(a_load_starts_walk, cmd.load |=> (state == ST_WALK), "load did not start a walk")
  `ASSERT_CLK(a_stop_ends_walk, (cmd.step && status.stop) |=> s_tready, "walk did not end on stop")
  `ASSERT_CLK_ALWAYS(a_no_load_and_step, !(cmd.load && cmd.step), "load and step together")

endmodule

// ===== design/grid_line_tile_walker.sv =====
// The first cell of a line reaches m_tdata once its accepted beat loads the walk and a
// walk step fills the output register. Throughput: one cell per cycle while m_tready is
// high; a line has N cells, N = max of the column and row distance plus one (at most 64).
// Walk step and output register set that rate: one Bresenham step per cycle if out_free.
// Reset (rst, synchronous): walk idle, output empty, grid_columns and grid_rows back to 16.
module grid_line_tile_walker (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration writes: index 0 is grid_columns, index 1 is grid_rows.
  input  logic                           cfg_we,
  input  logic [gltw_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [gltw_pkg::DIM_W-1:0]     cfg_data,
  // Line request beat.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gltw_pkg::IN_W-1:0]      s_tdata,  // start_col, start_row, end_col, end_row
  // One beat per line cell; tlast marks the cell equal to the end point.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gltw_pkg::OUT_W-1:0]     m_tdata,  // tile_index, zero pad
  output logic                           m_tlast   // is_last
);

  gltw_pkg::dp_cmd_t    cmd;
  gltw_pkg::dp_status_t status;

  // The controller accepts one line at a time and clocks the walk forward
  // whenever the output register is free or being emptied this cycle.
  gltw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the walk position, the error term and the grid size,
  // and forms the saturated tile index of each cell into the output register.
  gltw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
